// ===== hw/rtl/fwt_pkg.sv =====
package fwt_pkg;

  localparam int unsigned TagW = 64;
  localparam int unsigned SizeW = 8;
  localparam int unsigned OccW = 5;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_FULL     = 3'd1,
    ST_REMOVED  = 3'd2,
    ST_NOFIT    = 3'd3,
    ST_EMPTY    = 3'd4
  } status_e;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef struct packed {
    logic [TagW-1:0]  tag;
    logic [SizeW-1:0] size;
  } entry_t;

  typedef struct packed {
    logic             operation;
    logic [TagW-1:0]  party_tag;
    logic [SizeW-1:0] party_size;
    logic [SizeW-1:0] seat_limit;
  } in_word_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [TagW-1:0]  removed_tag;
    logic [SizeW-1:0] removed_size;
    logic [OccW-1:0]  occupancy;
  } out_word_t;

  typedef struct packed {
    logic             insert;
    logic             remove;
    logic [SizeW-1:0] limit;
    entry_t           fresh;
  } cell_cmd_t;

endpackage

// ===== hw/rtl/first_fit_waitlist_table_core.sv =====
// channel   | ports                       | handshake
// ----------+-----------------------------+---------------------------------
// request   | start, busy, in_word_i      | word taken when start & !busy
// result    | done_o, res_o               | one-cycle strobe, no back-pressure
//
// one word per cycle: busy stays low, the result shows on the cycle after the
// request word is taken, and every request gives exactly one result word.
// the cell row settles first fit, pick and one-place compaction combinationally.
// reset clears the fill count and the strobe; the cells need no clearing.
// the receiver cannot stall, so no result is ever held back.
module first_fit_waitlist_table_core #(
  parameter int unsigned DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  fwt_pkg::in_word_t  in_word_i,
  output logic               done_o,
  output fwt_pkg::out_word_t res_o
);
  import fwt_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0] count_q, count_d;
  logic            done_q;
  out_word_t       res_q, res_d;
  cell_cmd_t       cmd;
  logic            take;
  logic            full;
  logic            found;

  logic   hit_w   [DEPTH+1];
  entry_t sel_w   [DEPTH+1];
  entry_t entry_w [DEPTH+1];

  assign busy = 1'b0;
  assign take = start && !busy;
  assign full = count_q == CntW'(DEPTH);

  assign cmd.insert = take && (op_e'(in_word_i.operation) == OP_INSERT) && !full;
  assign cmd.remove = take && (op_e'(in_word_i.operation) == OP_REMOVE);
  assign cmd.limit  = in_word_i.seat_limit;
  assign cmd.fresh  = '{tag: in_word_i.party_tag, size: in_word_i.party_size};

  assign hit_w[0]       = 1'b0;
  assign sel_w[0]       = '0;
  assign entry_w[DEPTH] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    fwt_cell #(
      .Idx  (i),
      .CntW (CntW)
    ) u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .count_i     (count_q),
      .prior_hit_i (hit_w[i]),
      .hit_o       (hit_w[i+1]),
      .sel_i       (sel_w[i]),
      .sel_o       (sel_w[i+1]),
      .younger_i   (entry_w[i+1]),
      .entry_o     (entry_w[i])
    );
  end

  assign found = hit_w[DEPTH];

  always_comb begin
    count_d = count_q;
    res_d   = '0;
    if (cmd.insert) begin
      count_d = count_q + CntW'(1);
    end else if (cmd.remove && found) begin
      count_d = count_q - CntW'(1);
    end
    if (op_e'(in_word_i.operation) == OP_INSERT) begin
      res_d.status = full ? ST_FULL : ST_INSERTED;
    end else if (count_q == '0) begin
      res_d.status = ST_EMPTY;
    end else if (!found) begin
      res_d.status = ST_NOFIT;
    end else begin
      res_d.status       = ST_REMOVED;
      res_d.removed_tag  = sel_w[DEPTH].tag;
      res_d.removed_size = sel_w[DEPTH].size;
    end
    res_d.occupancy = OccW'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= take;
      if (take) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== hw/rtl/fwt_cell.sv =====
module fwt_cell #(
  parameter int unsigned Idx  = 0,
  parameter int unsigned CntW = 5
) (
  input  logic              clk_i,
  input  fwt_pkg::cell_cmd_t cmd_i,
  input  logic [CntW-1:0]   count_i,
  input  logic              prior_hit_i,
  output logic              hit_o,
  input  fwt_pkg::entry_t   sel_i,
  output fwt_pkg::entry_t   sel_o,
  input  fwt_pkg::entry_t   younger_i,
  output fwt_pkg::entry_t   entry_o
);
  import fwt_pkg::*;

  entry_t entry_q, entry_d;
  logic   occupied;
  logic   mine;
  logic   first;

  assign occupied = CntW'(Idx) < count_i;
  assign mine     = occupied && (entry_q.size <= cmd_i.limit);
  assign first    = mine && !prior_hit_i;
  assign hit_o    = prior_hit_i || mine;
  assign sel_o    = first ? entry_q : sel_i;
  assign entry_o  = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.remove && hit_o) begin
      entry_d = younger_i;
    end else if (cmd_i.insert && (count_i == CntW'(Idx))) begin
      entry_d = cmd_i.fresh;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule
